FILE: rtl/core/grouped_sparse_stats_accumulator_unit_macros.svh
// assertion macros for the grouped sparse stats accumulator
// used by the top level only; no other dependencies
`ifndef GROUPED_SPARSE_STATS_ACCUMULATOR_UNIT_MACROS_SVH
`define GROUPED_SPARSE_STATS_ACCUMULATOR_UNIT_MACROS_SVH

// antecedent this cycle implies consequent in the next cycle
`define GSSA_CHECK_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define GSSA_CHECK_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gssa_pkg.sv
// shared types and constants of the grouped sparse stats accumulator
// no dependencies
package gssa_pkg;

  localparam int OP_W    = 2;
  localparam int FEAT_W  = 10;
  localparam int GROUP_W = 4;
  localparam int VALUE_W = 24;
  localparam int NZ_W    = 16;
  localparam int SUM_W   = 40;
  localparam int MEAN_W  = 24;
  localparam int VAR_W   = 48;
  localparam int SQ_W    = 64;
  localparam int STAT_W  = 2;
  localparam int MASK_W  = 4;
  localparam int GSIZE_W = 16;
  localparam int IDX_W   = 18;
  localparam int VSQ_W   = 48;
  localparam int NUM_W   = 82;
  localparam int DIVD_W  = 80;
  localparam int DIVS_W  = 32;

  // request op codes
  localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_SINGLE = 2'd2;

  // stats mask bits
  localparam int MB_NZ   = 0;
  localparam int MB_SUM  = 1;
  localparam int MB_MEAN = 2;
  localparam int MB_VAR  = 3;
  localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

  typedef enum logic [1:0] {
    CMD_COUNT,
    CMD_ACCUM,
    CMD_READ,
    CMD_READ_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [IDX_W-1:0]           idx;
    logic [GROUP_W-1:0]         group;
    logic signed [VALUE_W-1:0]  value;
    logic [VSQ_W-1:0]           vsq;
  } cmd_t;

  typedef struct packed {
    logic [NZ_W-1:0]          nz;
    logic signed [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]          sq;
  } row_t;

  // queue head toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // back end control toward the front end
  typedef struct packed {
    logic pop;
    logic init;
  } back_ctl_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_DIVM,
    B_MUL,
    B_DIVV,
    B_OUT
  } back_state_t;

endpackage

FILE: rtl/core/gssa_front.sv
// front end: takes requests, classifies them and queues commands
// depends on gssa_pkg
module gssa_front import gssa_pkg::*; #(
  parameter int FEATURE_COUNT = 1024,
  parameter int N_GROUPS      = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            in_op,
  input  logic [FEAT_W-1:0]          in_feature,
  input  logic [GROUP_W-1:0]         in_group,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  back_ctl_t                  ctl,
  output q_head_t                    head
);

  localparam int QD = 2;

  cmd_t                          q_mem_r [QD];
  logic                          wr_ptr_r, rd_ptr_r;
  logic [1:0]                    cnt_r;
  logic                          full, push, keep, idx_ok;
  cmd_t                          cmd;
  logic signed [2*VALUE_W-1:0]   vprod;

  // classify the incoming request
  always_comb begin
    idx_ok = (32'(in_feature) < FEATURE_COUNT) && (32'(in_group) < N_GROUPS);
    vprod  = in_value * in_value;
    cmd.idx   = IDX_W'(32'(in_feature) * N_GROUPS + 32'(in_group));
    cmd.group = in_group;
    cmd.value = in_value;
    cmd.vsq   = VSQ_W'(vprod);
    cmd.kind  = CMD_COUNT;
    keep      = 1'b0;
    unique case (in_op)
      OP_COUNT: begin
        cmd.kind = CMD_COUNT;
        keep     = idx_ok;
      end
      OP_ACCUM: begin
        cmd.kind = CMD_ACCUM;
        keep     = idx_ok && (in_value != '0);
      end
      OP_READ: begin
        cmd.kind = idx_ok ? CMD_READ : CMD_READ_BAD;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full = (cnt_r == 2'(QD));
  assign busy = full || ctl.init;
  assign push = start && !busy && keep;

  // command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (ctl.pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(ctl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cmd;
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_mem_r[rd_ptr_r];

endmodule

FILE: rtl/core/gssa_div.sv
// restoring divider, one quotient bit per cycle
// depends on gssa_pkg
module gssa_div import gssa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIVD_W-1:0]  dividend,
  input  logic [DIVS_W-1:0]  divisor,
  output logic               done,
  output logic [DIVD_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic [DIVD_W-1:0]  quo_r;
  logic [DIVS_W-1:0]  rem_r, div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r, done_r;
  logic [DIVS_W:0]    trial, diff;
  logic               take;

  // one trial subtraction
  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    diff  = trial - {1'b0, div_r};
    take  = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], take};
      rem_r <= take ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/gssa_back.sv
// back end: table memories, update sequencer and stats arithmetic
// depends on gssa_pkg and gssa_div
module gssa_back import gssa_pkg::*; #(
  parameter int FEATURE_COUNT = 1024,
  parameter int N_GROUPS      = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [MASK_W-1:0]         cfg_wr_data,
  input  q_head_t                   head,
  output back_ctl_t                 ctl,
  output logic                      out_valid,
  output logic [NZ_W-1:0]           out_nz_count,
  output logic signed [SUM_W-1:0]   out_sum,
  output logic signed [MEAN_W-1:0]  out_mean,
  output logic [VAR_W-1:0]          out_variance,
  output logic [STAT_W-1:0]         out_status
);

  localparam int CELL_COUNT = FEATURE_COUNT * N_GROUPS;
  localparam int CW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int GW = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;

  // multiply sequence steps
  localparam logic [2:0] MS_DENOM = 3'd0;
  localparam logic [2:0] MS_SQ_LO = 3'd1;
  localparam logic [2:0] MS_SQ_HI = 3'd2;
  localparam logic [2:0] MS_LO_LO = 3'd3;
  localparam logic [2:0] MS_LO_HI = 3'd4;
  localparam logic [2:0] MS_HI_HI = 3'd5;
  localparam logic [2:0] MS_FOLD  = 3'd6;
  localparam logic [2:0] MS_DONE  = 3'd7;

  localparam logic [MEAN_W-1:0] MEAN_POS_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_NEG_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  back_state_t state_r, state_nxt;

  row_t                     cell_mem [CELL_COUNT];
  logic [GSIZE_W-1:0]       gsize_mem [N_GROUPS];
  row_t                     cell_rd_r;
  logic [GSIZE_W-1:0]       gsize_rd_r;

  logic [CW-1:0]            clr_cnt_r;
  logic [2:0]               step_r;
  logic [MASK_W-1:0]        mask_r;
  cmd_t                     cur_r;
  logic [GSIZE_W-1:0]       n_r;
  logic [NZ_W-1:0]          nz_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]         mag_r;
  logic [SQ_W-1:0]          sq_r;
  logic [DIVS_W-1:0]        d_r;
  logic [NUM_W-1:0]         acc_r;
  logic [63:0]              prod_r;
  logic [MEAN_W-1:0]        mean_r;
  logic [VAR_W-1:0]         var_r;
  logic [STAT_W-1:0]        stat_r;
  logic                     out_valid_r;
  logic [NZ_W-1:0]          out_nz_r;
  logic [SUM_W-1:0]         out_sum_r;
  logic [MEAN_W-1:0]        out_mean_r;
  logic [VAR_W-1:0]         out_var_r;
  logic [STAT_W-1:0]        out_stat_r;

  logic                     cell_we, gsize_we, clr_last, pop;
  logic [CW-1:0]            cell_wa;
  logic [GW-1:0]            gsize_wa;
  row_t                     cell_wd, acc_row;
  logic [GSIZE_W-1:0]       gsize_wd;
  logic signed [SUM_W:0]    sum_ext;
  logic [SQ_W:0]            sq_ext;
  logic [SUM_W-1:0]         exec_mag;
  logic                     div_start, div_done;
  logic [DIVD_W-1:0]        div_dividend, div_quo;
  logic [DIVS_W-1:0]        div_divisor;
  logic [31:0]              mul_a, mul_b;
  logic [31:0]              mag_lo, mag_hi;
  logic [NUM_W-1:0]         acc_term;
  logic                     acc_en, acc_sub;
  logic [MEAN_W-1:0]        mean_sat;
  logic [VAR_W-1:0]         var_sat;

  assign clr_last = (clr_cnt_r == CW'(CELL_COUNT - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: if (clr_last) state_nxt = B_IDLE;
      B_IDLE:  if (head.valid) state_nxt = B_EXEC;
      B_EXEC: begin
        priority case (cur_r.kind)
          CMD_READ:     state_nxt = (gsize_rd_r == '0) ? B_OUT : B_DIVM;
          CMD_READ_BAD: state_nxt = B_OUT;
          default:      state_nxt = B_IDLE;
        endcase
      end
      B_DIVM: if (div_done) state_nxt = (n_r == GSIZE_W'(1)) ? B_OUT : B_MUL;
      B_MUL: begin
        if (step_r == MS_DONE) state_nxt = acc_r[NUM_W-1] ? B_OUT : B_DIVV;
      end
      B_DIVV:  if (div_done) state_nxt = B_OUT;
      B_OUT:   state_nxt = B_IDLE;
      default: state_nxt = B_CLEAR;
    endcase
  end

  // updated table rows
  always_comb begin
    sum_ext = {cell_rd_r.sum[SUM_W-1], cell_rd_r.sum} + (SUM_W+1)'(cur_r.value);
    sq_ext  = {1'b0, cell_rd_r.sq} + (SQ_W+1)'(cur_r.vsq);
    acc_row.nz  = (cell_rd_r.nz == '1) ? cell_rd_r.nz : cell_rd_r.nz + 1'b1;
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      acc_row.sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_row.sum = sum_ext[SUM_W-1:0];
    end
    acc_row.sq = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
    exec_mag = cell_rd_r.sum[SUM_W-1] ? SUM_W'(-cell_rd_r.sum) : cell_rd_r.sum;
  end

  // outputs of the sequencer
  always_comb begin
    pop          = 1'b0;
    cell_we      = 1'b0;
    gsize_we     = 1'b0;
    cell_wa      = CW'(cur_r.idx);
    gsize_wa     = GW'(cur_r.group);
    cell_wd      = acc_row;
    gsize_wd     = (gsize_rd_r == '1) ? gsize_rd_r : gsize_rd_r + 1'b1;
    div_start    = 1'b0;
    div_dividend = DIVD_W'(exec_mag);
    div_divisor  = DIVS_W'(gsize_rd_r);
    unique case (state_r)
      B_CLEAR: begin
        cell_we  = 1'b1;
        cell_wa  = clr_cnt_r;
        cell_wd  = '0;
        gsize_we = (32'(clr_cnt_r) < N_GROUPS);
        gsize_wa = GW'(clr_cnt_r);
        gsize_wd = '0;
      end
      B_IDLE: pop = head.valid;
      B_EXEC: begin
        cell_we   = (cur_r.kind == CMD_ACCUM);
        gsize_we  = (cur_r.kind == CMD_COUNT);
        div_start = (cur_r.kind == CMD_READ) && (gsize_rd_r != '0);
      end
      B_MUL: begin
        div_start    = (step_r == MS_DONE) && !acc_r[NUM_W-1];
        div_dividend = acc_r[DIVD_W-1:0];
        div_divisor  = d_r;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign ctl.pop  = pop;
  assign ctl.init = (state_r == B_CLEAR);

  // table memories
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rd_r <= cell_mem[CW'(head.cmd.idx)];
  end

  always_ff @(posedge clk) begin
    if (gsize_we) gsize_mem[gsize_wa] <= gsize_wd;
    gsize_rd_r <= gsize_mem[GW'(head.cmd.group)];
  end

  // shared multiplier operands
  assign mag_lo = mag_r[31:0];
  assign mag_hi = 32'(mag_r[SUM_W-1:32]);

  always_comb begin
    unique case (step_r)
      MS_DENOM: begin mul_a = 32'(n_r);     mul_b = 32'(n_r - 1'b1); end
      MS_SQ_LO: begin mul_a = sq_r[31:0];  mul_b = 32'(n_r);         end
      MS_SQ_HI: begin mul_a = sq_r[63:32]; mul_b = 32'(n_r);         end
      MS_LO_LO: begin mul_a = mag_lo;      mul_b = mag_lo;           end
      MS_LO_HI: begin mul_a = mag_lo;      mul_b = mag_hi;           end
      MS_HI_HI: begin mul_a = mag_hi;      mul_b = mag_hi;           end
      default:  begin mul_a = '0;          mul_b = '0;               end
    endcase
  end

  // numerator fold: n*sumsq - sum^2, one partial product a cycle
  always_comb begin
    acc_en   = 1'b1;
    acc_sub  = 1'b0;
    acc_term = NUM_W'(prod_r);
    unique case (step_r)
      MS_SQ_HI: acc_term = NUM_W'(prod_r);
      MS_LO_LO: acc_term = NUM_W'(prod_r) << 32;
      MS_LO_HI: begin acc_sub = 1'b1; acc_term = NUM_W'(prod_r); end
      MS_HI_HI: begin acc_sub = 1'b1; acc_term = NUM_W'(prod_r) << 33; end
      MS_FOLD:  begin acc_sub = 1'b1; acc_term = NUM_W'(prod_r) << 64; end
      default:  acc_en = 1'b0;
    endcase
  end

  // saturation of quotients
  always_comb begin
    if (sum_r[SUM_W-1]) begin
      mean_sat = (div_quo > DIVD_W'(MEAN_NEG_MIN)) ? MEAN_NEG_MIN : MEAN_W'(-div_quo[MEAN_W-1:0]);
    end else begin
      mean_sat = (div_quo > DIVD_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX : div_quo[MEAN_W-1:0];
    end
    var_sat = (div_quo > DIVD_W'({VAR_W{1'b1}})) ? '1 : div_quo[VAR_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      mask_r      <= MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == B_OUT);
      if (cfg_wr_en) mask_r <= cfg_wr_data;
      if (state_r == B_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == B_MUL) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) cur_r <= head.cmd;
    if (state_r == B_EXEC) begin
      n_r    <= gsize_rd_r;
      nz_r   <= (cur_r.kind == CMD_READ) ? cell_rd_r.nz : '0;
      sum_r  <= (cur_r.kind == CMD_READ) ? cell_rd_r.sum : '0;
      sq_r   <= cell_rd_r.sq;
      mag_r  <= exec_mag;
      mean_r <= '0;
      var_r  <= '0;
      acc_r  <= '0;
      if (cur_r.kind != CMD_READ || gsize_rd_r == '0) begin
        stat_r <= ST_EMPTY;
      end else if (gsize_rd_r == GSIZE_W'(1)) begin
        stat_r <= ST_SINGLE;
      end else begin
        stat_r <= ST_OK;
      end
    end
    if (state_r == B_DIVM && div_done) mean_r <= mean_sat;
    if (state_r == B_DIVV && div_done) var_r <= var_sat;
    if (state_r == B_MUL) begin
      prod_r <= mul_a * mul_b;
      if (step_r == MS_SQ_LO) d_r <= prod_r[DIVS_W-1:0];
      if (acc_en) acc_r <= acc_sub ? acc_r - acc_term : acc_r + acc_term;
    end
    if (state_r == B_OUT) begin
      out_nz_r   <= mask_r[MB_NZ]   ? nz_r : '0;
      out_sum_r  <= mask_r[MB_SUM]  ? sum_r : '0;
      out_mean_r <= mask_r[MB_MEAN] ? mean_r : '0;
      out_var_r  <= mask_r[MB_VAR]  ? var_r : '0;
      out_stat_r <= stat_r;
    end
  end

  gssa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid     = out_valid_r;
  assign out_nz_count  = out_nz_r;
  assign out_sum       = out_sum_r;
  assign out_mean      = out_mean_r;
  assign out_variance  = out_var_r;
  assign out_status    = out_stat_r;

endmodule

FILE: rtl/core/grouped_sparse_stats_accumulator_unit.sv
// top level of the grouped sparse stats accumulator
// depends on gssa_pkg, gssa_front, gssa_back and the macros header
//
// channel   signals                                   handshake
// input     in_op in_feature in_group in_value        start & !busy
// result    out_nz_count out_sum out_mean             out_valid, one cycle
//           out_variance out_status
// config    cfg_wr_data                               cfg_wr_en
//
// count and accumulate hold the back end for a table read, then a write
// a full read strobes its result after two passes of the bit-serial divider;
// a group of one needs one pass, an empty group none
// after reset a clearing pass over all FEATURE_COUNT*N_GROUPS cells holds busy high
// busy rises when both queue entries wait; the receiver cannot stall
`include "grouped_sparse_stats_accumulator_unit_macros.svh"

module grouped_sparse_stats_accumulator_unit import gssa_pkg::*; #(
  parameter int FEATURE_COUNT = 1024,
  parameter int N_GROUPS      = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           in_op,
  input  logic [FEAT_W-1:0]         in_feature,
  input  logic [GROUP_W-1:0]        in_group,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      cfg_wr_en,
  input  logic [MASK_W-1:0]         cfg_wr_data,
  output logic                      out_valid,
  output logic [NZ_W-1:0]           out_nz_count,
  output logic signed [SUM_W-1:0]   out_sum,
  output logic signed [MEAN_W-1:0]  out_mean,
  output logic [VAR_W-1:0]          out_variance,
  output logic [STAT_W-1:0]         out_status
);

  q_head_t   head;
  back_ctl_t ctl;

  // request intake and queue
  gssa_front #(
    .FEATURE_COUNT (FEATURE_COUNT),
    .N_GROUPS      (N_GROUPS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_op      (in_op),
    .in_feature (in_feature),
    .in_group   (in_group),
    .in_value   (in_value),
    .ctl        (ctl),
    .head       (head)
  );

  // table update and stats
  gssa_back #(
    .FEATURE_COUNT (FEATURE_COUNT),
    .N_GROUPS      (N_GROUPS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .head          (head),
    .ctl           (ctl),
    .out_valid     (out_valid),
    .out_nz_count  (out_nz_count),
    .out_sum       (out_sum),
    .out_mean      (out_mean),
    .out_variance  (out_variance),
    .out_status    (out_status)
  );

  // checks
  `GSSA_CHECK_NEXT(a_out_single, clk, rst_n, out_valid, !out_valid, "result strobe repeated")
  `GSSA_CHECK_NOW(a_init_quiet, clk, rst_n, ctl.init, !out_valid, "result during clearing")
  `GSSA_CHECK_NOW(a_init_busy, clk, rst_n, ctl.init, busy, "request taken during clearing")
  `GSSA_CHECK_NOW(a_pop_valid, clk, rst_n, ctl.pop, head.valid, "pop from empty queue")

endmodule
